// ----- src/assert_macros.svh -----
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define AST_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, checked while out of reset
`define AST_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- src/stsel_pkg.sv -----
// Shared constants and types of the spectrum top bins selector.
`timescale 1ns / 1ps

package stsel_pkg;

  localparam int unsigned TOP_MAX  = 16;
  localparam int unsigned MAX_BINS = 4096;
  localparam int unsigned IDX_W    = 13;
  localparam int unsigned MAG_W    = 32;
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned CNT_W    = $clog2(TOP_MAX + 1);

  // One ranked entry: magnitude squared and bin index
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [IDX_W-1:0] idx;
  } entry_t;

  // A bin leaving the magnitude pipeline
  typedef struct packed {
    logic   valid;
    logic   last;
    entry_t ent;
  } bin_t;

  // Commands broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic pop;
    logic clear;
  } cell_ctrl_t;

endpackage

// ----- src/stsel_mag.sv -----
// Two-stage magnitude-squared pipeline: squares, then their sum.
`timescale 1ns / 1ps

module stsel_mag (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic signed [stsel_pkg::SMP_W-1:0]    re_i,
  input  logic signed [stsel_pkg::SMP_W-1:0]    im_i,
  input  logic                                  last_i,
  input  logic        [stsel_pkg::IDX_W-1:0]    idx_i,
  output stsel_pkg::bin_t                       bin_o
);
  import stsel_pkg::*;

  logic signed [2*SMP_W-1:0] prod_re;
  logic signed [2*SMP_W-1:0] prod_im;
  logic        [2*SMP_W-1:0] sq_re_q;
  logic        [2*SMP_W-1:0] sq_im_q;
  logic        [IDX_W-1:0]   idx_q;
  logic                      last_q;
  logic                      v1_q;
  logic                      v2_q;
  logic        [MAG_W-1:0]   mag_q;
  logic        [IDX_W-1:0]   idx2_q;
  logic                      last2_q;

  // Square each part; the result is never negative and at most 2^30
  assign prod_re = re_i * re_i;
  assign prod_im = im_i * im_i;

  // Stage one: valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
    end
  end

  // Stage one: registered squares
  always_ff @(posedge clk_i) begin
    sq_re_q <= prod_re;
    sq_im_q <= prod_im;
    idx_q   <= idx_i;
    last_q  <= last_i;
  end

  // Stage two: valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  // Stage two: sum of squares
  always_ff @(posedge clk_i) begin
    mag_q   <= MAG_W'(sq_re_q) + MAG_W'(sq_im_q);
    idx2_q  <= idx_q;
    last2_q <= last_q;
  end

  assign bin_o = {v2_q, last2_q, mag_q, idx2_q};

endmodule

// ----- src/stsel_cell.sv -----
// One cell of the ranking chain: holds one entry, compares, shifts down or up.
`timescale 1ns / 1ps

module stsel_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stsel_pkg::cell_ctrl_t ctrl_i,
  input  stsel_pkg::entry_t     new_i,
  input  stsel_pkg::entry_t     prev_i,
  input  logic                  prev_gt_i,
  input  stsel_pkg::entry_t     next_i,
  output stsel_pkg::entry_t     ent_o,
  output logic                  gt_o
);
  import stsel_pkg::*;

  entry_t ent_q;
  entry_t ent_d;

  // Strictly greater: on a tie the stored entry keeps its place
  assign gt_o = new_i.mag > ent_q.mag;

  // Clear, pop towards the head, or take part in an insertion
  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.clear) begin
      ent_d = '0;
    end else if (ctrl_i.pop) begin
      ent_d = next_i;
    end else if (ctrl_i.insert) begin
      if (prev_gt_i) begin
        ent_d = prev_i;
      end else if (gt_o) begin
        ent_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

// ----- src/spectrum_top_bins_selector.sv -----
// Top level: bin numbering, magnitude pipeline, ranking chain and report control.
`timescale 1ns / 1ps

// Spectrum top bins selector. Bins arrive on the slave stream, real part in
// tdata[15:0], imaginary part in tdata[31:16], tlast on the final bin; they are
// numbered from 1. Each bin's magnitude squared is ranked by a chain of
// TOP_MAX cells, one compare per cell, ties keeping the earlier bin. Ordinary
// bins are taken one per cycle. After the final bin the block takes no input:
// the bin passes the multiply and add stages and is ranked, then top_count
// report items follow, one per cycle when the master side is ready (index in
// tdata[12:0], tlast on the last one), popped from the head of the chain. The
// next spectrum is accepted the cycle after the last report item. top_count is
// written through cfg_we_i/cfg_wdata_i, clamped to 1..TOP_MAX, and read when a
// report starts.
module spectrum_top_bins_selector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream: tdata = {imag_part[15:0], real_part[15:0]}, tlast = is_last
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  // master stream: tdata = {3'b0, top_bin[12:0]}, tlast = last_of_run
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // top_count register
  input  logic        cfg_we_i,
  input  logic [stsel_pkg::CFG_W-1:0] cfg_wdata_i
);
  import stsel_pkg::*;

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_FLUSH   = 3'b010,
    ST_DRAIN   = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   top_count_q;
  logic [CNT_W-1:0]   remain_q, remain_d;
  logic [IDX_W-1:0]   bin_num_q, bin_num_d;
  logic               in_acc;
  logic               out_acc;
  bin_t               bin;
  cell_ctrl_t         ctrl;
  entry_t             ent   [TOP_MAX];
  logic               gt    [TOP_MAX];

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;

  // Clamp the written count into 1..TOP_MAX
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
    logic [CNT_W:0] w;
    w = (CNT_W + 1)'(v);
    if (w == '0) begin
      return CNT_W'(1);
    end else if (w > (CNT_W + 1)'(TOP_MAX)) begin
      return CNT_W'(TOP_MAX);
    end else begin
      return w[CNT_W-1:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      top_count_q <= clamp_count(cfg_wdata_i);
    end
  end

  // Number bins from 1, saturate at MAX_BINS, restart after the final bin
  always_comb begin
    bin_num_d = bin_num_q;
    if (in_acc) begin
      if (s_axis_tlast) begin
        bin_num_d = IDX_W'(1);
      end else if (bin_num_q < IDX_W'(MAX_BINS)) begin
        bin_num_d = bin_num_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_num_q <= IDX_W'(1);
    end else begin
      bin_num_q <= bin_num_d;
    end
  end

  stsel_mag u_mag (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_acc),
    .re_i       (s_axis_tdata[SMP_W-1:0]),
    .im_i       (s_axis_tdata[2*SMP_W-1:SMP_W]),
    .last_i     (s_axis_tlast),
    .idx_i      (bin_num_q),
    .bin_o      (bin)
  );

  // Collect, wait for the final bin to be ranked, then report
  always_comb begin
    state_d  = state_q;
    remain_d = remain_q;
    case (state_q)
      ST_COLLECT: begin
        if (in_acc && s_axis_tlast) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (bin.valid && bin.last) begin
          state_d  = ST_DRAIN;
          remain_d = top_count_q;
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          if (remain_q == CNT_W'(1)) begin
            state_d = ST_COLLECT;
          end else begin
            remain_d = remain_q - CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_COLLECT;
      remain_q <= '0;
    end else begin
      state_q  <= state_d;
      remain_q <= remain_d;
    end
  end

  // Chain commands: rank each bin, pop the head per report item, clear after the last
  always_comb begin
    ctrl.insert = bin.valid;
    ctrl.pop    = out_acc && (remain_q != CNT_W'(1));
    ctrl.clear  = out_acc && (remain_q == CNT_W'(1));
  end

  for (genvar i = 0; i < TOP_MAX; i++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;
    logic   prev_gt;

    if (i == 0) begin : g_head
      assign prev_ent = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_ent = ent[i-1];
      assign prev_gt  = gt[i-1];
    end

    if (i == TOP_MAX - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ent[i+1];
    end

    stsel_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .new_i     (bin.ent),
      .prev_i    (prev_ent),
      .prev_gt_i (prev_gt),
      .next_i    (next_ent),
      .ent_o     (ent[i]),
      .gt_o      (gt[i])
    );
  end

  // Ports
  assign s_axis_tready = (state_q == ST_COLLECT);
  assign m_axis_tvalid = (state_q == ST_DRAIN);
  assign m_axis_tdata  = 16'(ent[0].idx);
  assign m_axis_tlast  = (remain_q == CNT_W'(1));

endmodule

// ----- src/stsel_checker.sv -----
// Port-level checker for the spectrum top bins selector, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stsel_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        cfg_we_i,
  input logic [stsel_pkg::CFG_W-1:0] cfg_wdata_i
);

  logic in_last_acc;
  logic out_last_acc;

  assign in_last_acc  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign out_last_acc = m_axis_tvalid && m_axis_tready && m_axis_tlast;

  // No input is taken while a report is pending
  `AST_SAME(a_no_input_in_report, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  // An accepted final bin closes the input
  `AST_NEXT(a_close_after_last, clk_i, rst_ni, in_last_acc, !s_axis_tready)
  // The report ends with its last item
  `AST_NEXT(a_report_ends, clk_i, rst_ni, out_last_acc, !m_axis_tvalid)
  // A stalled report item holds
  `AST_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind spectrum_top_bins_selector stsel_checker u_stsel_checker (.*);

// ----- verif/top_bins_checker.sv -----
// Checker for the spectrum top bins selector: ranks accepted bins and compares report items.
`timescale 1ns / 1ps

module top_bins_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  // slave stream as seen at the block: tdata = {imag_part, real_part}
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,
  input  logic             s_axis_tlast,
  // master stream as seen at the block: tdata = {3'b0, top_bin}
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [15:0]      m_axis_tdata,
  input  logic             m_axis_tlast,
  input  logic             cfg_we_i,
  input  logic [stsel_pkg::CFG_W-1:0] cfg_wdata_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o,
  output int               reports_o
);
  import stsel_pkg::*;

  // One report item the block owes
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } report_item_t;

  report_item_t     owed_reports[$];
  logic [MAG_W-1:0] ranked_mag[TOP_MAX];
  logic [IDX_W-1:0] ranked_idx[TOP_MAX];
  logic [IDX_W-1:0] bin_number;
  logic [CFG_W-1:0] report_len;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d, want %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // Power of one bin; exact, at most 2^31
  function automatic logic [MAG_W-1:0] power_of(input logic [15:0] re, input logic [15:0] im);
    longint a;
    longint b;
    a = longint'($signed(re));
    b = longint'($signed(im));
    return MAG_W'(a * a + b * b);
  endfunction

  function automatic void clear_ranking();
    for (int i = 0; i < TOP_MAX; i++) begin
      ranked_mag[i] = '0;
      ranked_idx[i] = '0;
    end
  endfunction

  // Insert only where strictly greater, so a tie leaves the earlier bin in front
  function automatic void rank_bin(input logic [MAG_W-1:0] mag, input logic [IDX_W-1:0] idx);
    logic placed;
    placed = 1'b0;
    for (int i = 0; i < TOP_MAX; i++) begin
      if (!placed && mag > ranked_mag[i]) begin
        for (int j = TOP_MAX - 1; j > i; j--) begin
          ranked_mag[j] = ranked_mag[j-1];
          ranked_idx[j] = ranked_idx[j-1];
        end
        ranked_mag[i] = mag;
        ranked_idx[i] = idx;
        placed = 1'b1;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict
    report_item_t want;
    if (!rst_ni) begin
      clear_ranking();
      bin_number = IDX_W'(1);
      report_len = CFG_W'(1);
      owed_reports.delete();
    end else begin
      // compare a report item with the oldest one owed
      if (m_axis_tvalid && m_axis_tready) begin
        checked_o++;
        if (owed_reports.size() == 0) begin
          report_mismatch("report item with nothing owed, index", m_axis_tdata, -1);
        end else begin
          want = owed_reports.pop_front();
          if (m_axis_tdata !== {3'b000, want.idx})
            report_mismatch("bin index", m_axis_tdata, want.idx);
          if (m_axis_tlast !== want.last)
            report_mismatch("last of run", m_axis_tlast, want.last);
        end
      end
      // hold the clamped top_count
      if (cfg_we_i) begin
        if (cfg_wdata_i == 0) begin
          report_len = CFG_W'(1);
        end else if (cfg_wdata_i > TOP_MAX) begin
          report_len = CFG_W'(TOP_MAX);
        end else begin
          report_len = cfg_wdata_i;
        end
      end
      // rank the bin; on the final one owe the report and start over
      if (s_axis_tvalid && s_axis_tready) begin
        rank_bin(power_of(s_axis_tdata[15:0], s_axis_tdata[31:16]), bin_number);
        if (bin_number < MAX_BINS) bin_number++;
        if (s_axis_tlast) begin
          for (int k = 0; k < report_len; k++) begin
            want.idx  = ranked_idx[k];
            want.last = (k == report_len - 1);
            owed_reports.push_back(want);
          end
          reports_o++;
          clear_ranking();
          bin_number = IDX_W'(1);
        end
      end
    end
    pending_o = owed_reports.size();
  end

endmodule

// ----- verif/tb_spectrum_top_bins_selector.sv -----
// Testbench top: clock, reset, bin stimulus, report-side stalls and the verdict.
`timescale 1ns / 1ps

module tb_spectrum_top_bins_selector;
  import stsel_pkg::*;

  localparam int RUN_LIMIT     = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BINS   = 340;

  typedef enum int {MIX_FULL, MIX_SMALL, MIX_SPARSE, MIX_EXTREME} sample_mix_e;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata;
  logic             s_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [15:0]      m_axis_tdata;
  logic             m_axis_tlast;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  int fail_count;
  int pending;
  int checked;
  int reports;
  int burst_left;
  int bins_sent;
  int spectra_sent;
  int cycle_count = 0;

  spectrum_top_bins_selector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  top_bins_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .reports_o     (reports)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Timeout after %0d cycles, %0d report items still owed", cycle_count, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one bin in bursts with random gaps; return at the falling edge after acceptance
  task automatic send_bin(input logic [15:0] re, input logic [15:0] im, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {im, re};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    bins_sent++;
    if (last) spectra_sent++;
  endtask

  // Stop offering until every owed report item is out and the pipeline has emptied
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_sample(input sample_mix_e mix);
    case (mix)
      MIX_FULL:   return 16'($urandom);
      MIX_SMALL:  return 16'($urandom_range(0, 8) - 4);
      MIX_SPARSE: return ($urandom_range(0, 9) < 7) ? 16'h0000 : 16'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
    endcase
  endfunction

  // Report side: random ready in segments, with a long hold-off now and then
  initial begin : report_sink
    int seg_left;
    int ready_pct;
    int tick;
    m_axis_tready = 1'b0;
    seg_left = 0;
    ready_pct = 100;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      tick++;
      if (tick % 1500 == 700) begin
        // hold off long enough for the block to back up onto its input
        m_axis_tready <= 1'b0;
        repeat (299) @(negedge clk_i);
        tick += 299;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(4, 40);
          case ($urandom_range(0, 3))
            0:       ready_pct = 100;
            1:       ready_pct = 75;
            2:       ready_pct = 25;
            default: ready_pct = 50;
          endcase
        end
        seg_left--;
        m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  initial begin : stimulus
    int rand_bins;
    int phase_left;
    int len;
    sample_mix_e mix;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    burst_left    = 0;
    bins_sent     = 0;
    spectra_sent  = 0;
    rst_ni        = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // top_count at its reset value: the largest possible power comes first
    send_bin(16'h8000, 16'h8000, 1'b0);
    send_bin(16'h7FFF, 16'h7FFF, 1'b0);
    send_bin(16'h0000, 16'h0000, 1'b1);
    wait_idle();

    // full list: ties keep the earlier bin, zero power never ranks, tail unfilled
    write_count(5'd16);
    send_bin(16'd3, 16'd4, 1'b0);
    send_bin(-16'sd5, 16'd0, 1'b0);
    send_bin(16'd0, -16'sd5, 1'b0);
    send_bin(16'h8000, 16'h0000, 1'b0);
    send_bin(16'h0000, 16'h7FFF, 1'b0);
    send_bin(16'd1, 16'd0, 1'b0);
    send_bin(16'd0, 16'd0, 1'b0);
    send_bin(16'hFFFF, 16'hFFFF, 1'b1);
    // one-bin spectra, empty and non-empty
    send_bin(16'd0, 16'd0, 1'b1);
    send_bin(16'd7, -16'sd7, 1'b1);
    wait_idle();

    // zero clamps up to one
    write_count(5'd0);
    send_bin(16'd100, 16'd0, 1'b0);
    send_bin(16'd200, 16'd0, 1'b1);
    wait_idle();

    // values above the list size clamp down; tie at full scale
    write_count(5'd31);
    send_bin(16'h8000, 16'h8000, 1'b0);
    send_bin(16'h8000, 16'h8000, 1'b0);
    send_bin(16'h7FFF, 16'h8000, 1'b1);
    wait_idle();
    write_count(5'd17);
    write_count(5'd4);
    send_bin(16'd1, 16'd1, 1'b0);
    send_bin(16'd2, 16'd2, 1'b0);
    send_bin(16'd3, 16'd3, 1'b0);
    send_bin(16'd4, 16'd4, 1'b0);
    send_bin(16'd5, 16'd5, 1'b1);

    // random spectra, mostly short, in phases with a new top_count each
    rand_bins = 0;
    phase_left = 0;
    while (rand_bins < RANDOM_BINS) begin
      if (phase_left == 0) begin
        wait_idle();
        case ($urandom_range(0, 4))
          0:       write_count(5'd1);
          1:       write_count(5'd16);
          2:       write_count(5'd0);
          3:       write_count(5'd31);
          default: write_count(CFG_W'($urandom_range(0, 31)));
        endcase
        phase_left = $urandom_range(3, 6);
      end
      phase_left--;
      mix = sample_mix_e'($urandom_range(0, 3));
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      for (int b = 1; b <= len; b++) begin
        send_bin(pick_sample(mix), pick_sample(mix), b == len);
      end
      rand_bins += len;
    end

    wait_idle();
    $display("Covered %0d bins in %0d spectra, top_count 1 to 16 with clamped writes,",
             bins_sent, spectra_sent);
    $display("ties, unfilled entries and long report stalls; %0d report items checked.",
             checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
